// File: hw/rtl/bhd_pkg.sv
package bhd_pkg;

   // Width of the timer and hold counters.
   localparam int COUNT_WIDTH = 16;
   // Width of each configuration register.
   localparam int CFG_WIDTH = 16;
   // Width used when comparing a register value against a counter value.
   localparam int SAT_WIDTH = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;

   localparam int CSR_ADDR_WIDTH = 2;
   localparam int REQ_DATA_WIDTH = 8;
   localparam int RSP_DATA_WIDTH = 8;

   localparam logic [CFG_WIDTH-1:0] HOLD_TIME_RESET  = CFG_WIDTH'(0);
   localparam logic [CFG_WIDTH-1:0] PRESS_TIME_RESET = CFG_WIDTH'(10);
   localparam logic [CFG_WIDTH-1:0] CHUNK_TIME_RESET = CFG_WIDTH'(50);

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   typedef enum logic [CSR_ADDR_WIDTH-1:0] {
      CSR_HOLD_TIME  = 2'd0,
      CSR_PRESS_TIME = 2'd1,
      CSR_CHUNK_TIME = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_IDLE    = 2'd0,
      MODE_CONFIRM = 2'd1,
      MODE_HOLD    = 2'd2
   } mode_type;

   typedef enum logic {
      FUNC_TICK = 1'b0,
      FUNC_EDGE = 1'b1
   } func_type;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] hold_time;
      logic [CFG_WIDTH-1:0] press_time;
      logic [CFG_WIDTH-1:0] chunk_time;
   } bhd_cfg_type;

   typedef struct packed {
      logic     long_press;
      mode_type mode;
   } bhd_result_type;

   // Clamps a register value to the largest value the counters can hold.
   function automatic logic [COUNT_WIDTH-1:0] sat_count(input logic [CFG_WIDTH-1:0] value);
      logic [SAT_WIDTH-1:0] wide;
      wide = SAT_WIDTH'(value);
      if (wide > SAT_WIDTH'(COUNT_MAX)) begin
         sat_count = COUNT_MAX;
      end else begin
         sat_count = COUNT_WIDTH'(wide);
      end
   endfunction

endpackage

// File: hw/rtl/bhd_csr.sv
module bhd_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [bhd_pkg::CSR_ADDR_WIDTH-1:0] csr_addr,
   input  logic [bhd_pkg::CFG_WIDTH-1:0]      csr_wdata,
   output bhd_pkg::bhd_cfg_type              cfg
);
   import bhd_pkg::*;

   bhd_cfg_type cfg_ff;
   bhd_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_HOLD_TIME:  cfg_in.hold_time  = csr_wdata;
            CSR_PRESS_TIME: cfg_in.press_time = csr_wdata;
            CSR_CHUNK_TIME: cfg_in.chunk_time = csr_wdata;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hold_time  <= HOLD_TIME_RESET;
         cfg_ff.press_time <= PRESS_TIME_RESET;
         cfg_ff.chunk_time <= CHUNK_TIME_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: hw/rtl/bhd_core.sv
module bhd_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step_en,
   input  logic                    func,
   input  logic                    pin_pressed,
   input  bhd_pkg::bhd_cfg_type    cfg,
   output bhd_pkg::bhd_result_type result
);
   import bhd_pkg::*;

   mode_type                 mode_ff;
   mode_type                 mode_in;
   logic [COUNT_WIDTH-1:0]   timer_count_ff;
   logic [COUNT_WIDTH-1:0]   timer_count_in;
   logic                     timer_armed_ff;
   logic                     timer_armed_in;
   logic [COUNT_WIDTH-1:0]   hold_remaining_ff;
   logic [COUNT_WIDTH-1:0]   hold_remaining_in;

   logic                     is_edge;
   logic                     press_edge;
   logic                     expired;
   logic [COUNT_WIDTH-1:0]   count_ticked;
   logic                     armed_ticked;
   logic [CFG_WIDTH-1:0]     chunk_eff;
   logic [SAT_WIDTH-1:0]     hold_wide;
   logic [SAT_WIDTH-1:0]     chunk_wide;
   logic [COUNT_WIDTH-1:0]   chunk_len;
   logic                     long_press;

   assign is_edge    = (func == FUNC_EDGE);
   assign press_edge = is_edge && pin_pressed;

   // The one-shot timer counts down on ticks; a count of zero or one expires.
   always_comb begin
      expired      = 1'b0;
      count_ticked = timer_count_ff;
      armed_ticked = timer_armed_ff;
      if (!is_edge && timer_armed_ff) begin
         if (timer_count_ff <= COUNT_WIDTH'(1)) begin
            expired      = 1'b1;
            count_ticked = '0;
            armed_ticked = 1'b0;
         end else begin
            count_ticked = timer_count_ff - COUNT_WIDTH'(1);
         end
      end
   end

   // Next hold chunk: the smaller of the remainder and the chunk size, where
   // a chunk size of zero counts as one.
   always_comb begin
      chunk_eff  = (cfg.chunk_time == '0) ? CFG_WIDTH'(1) : cfg.chunk_time;
      hold_wide  = SAT_WIDTH'(hold_remaining_ff);
      chunk_wide = SAT_WIDTH'(chunk_eff);
      chunk_len  = (hold_wide < chunk_wide) ? hold_remaining_ff : COUNT_WIDTH'(chunk_wide);
   end

   // Next mode.
   always_comb begin
      case (mode_ff)
         MODE_IDLE: begin
            mode_in = (press_edge && cfg.hold_time != '0) ? MODE_CONFIRM : MODE_IDLE;
         end
         MODE_CONFIRM: begin
            if (expired) begin
               mode_in = pin_pressed ? MODE_HOLD : MODE_IDLE;
            end else begin
               mode_in = MODE_CONFIRM;
            end
         end
         MODE_HOLD: begin
            if (expired) begin
               mode_in = (hold_remaining_ff == '0) ? MODE_IDLE : MODE_HOLD;
            end else if (press_edge) begin
               mode_in = MODE_CONFIRM;
            end else begin
               mode_in = MODE_HOLD;
            end
         end
         default: mode_in = MODE_IDLE;
      endcase
   end

   // Timer, remainder and long-press flag.
   always_comb begin
      timer_count_in    = count_ticked;
      timer_armed_in    = armed_ticked;
      hold_remaining_in = hold_remaining_ff;
      long_press        = 1'b0;
      case (mode_ff)
         MODE_IDLE: begin
            if (press_edge && cfg.hold_time != '0) begin
               hold_remaining_in = sat_count(cfg.hold_time);
               timer_count_in    = sat_count(cfg.press_time);
               timer_armed_in    = 1'b1;
            end
         end
         MODE_CONFIRM: begin
            if (expired && pin_pressed) begin
               timer_count_in    = chunk_len;
               timer_armed_in    = 1'b1;
               hold_remaining_in = hold_remaining_ff - chunk_len;
            end
         end
         MODE_HOLD: begin
            if (expired) begin
               if (hold_remaining_ff == '0) begin
                  long_press = pin_pressed;
               end else begin
                  timer_count_in    = chunk_len;
                  timer_armed_in    = 1'b1;
                  hold_remaining_in = hold_remaining_ff - chunk_len;
               end
            end else if (press_edge) begin
               timer_count_in = sat_count(cfg.press_time);
               timer_armed_in = 1'b1;
            end
         end
         default: long_press = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff           <= MODE_IDLE;
         timer_count_ff    <= '0;
         timer_armed_ff    <= 1'b0;
         hold_remaining_ff <= '0;
      end else if (step_en) begin
         mode_ff           <= mode_in;
         timer_count_ff    <= timer_count_in;
         timer_armed_ff    <= timer_armed_in;
         hold_remaining_ff <= hold_remaining_in;
      end
   end

   assign result.long_press = long_press;
   assign result.mode       = mode_in;

`ifndef ASSERT_OFF
   // A long press can only be reported out of hold waiting.
   assert property (@(posedge clock) disable iff (reset)
      step_en && long_press |-> mode_ff == MODE_HOLD)
      else $error("long press reported outside hold waiting");

   // Every way into idle leaves the timer disarmed.
   assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_IDLE |-> !timer_armed_ff)
      else $error("timer armed while idle");

   // A tick never wakes the block from idle.
   assert property (@(posedge clock) disable iff (reset)
      step_en && mode_ff == MODE_IDLE && !is_edge |=> mode_ff == MODE_IDLE)
      else $error("tick left idle");
`endif

endmodule

// File: hw/rtl/button_hold_debouncer_unit.sv
// Result path: an accepted item's result appears on the result channel once the
// step has moved it from the input register into the result register.
// Throughput: one item per cycle while the result side takes results; the input
// register refills whenever it is empty or the result register is empty or
// being drained in the same cycle.
// Reset: synchronous, active high; the block returns to idle with the timer
// disarmed and the configuration registers at their documented defaults.
module button_hold_debouncer_unit (
   input  logic                                clock,
   input  logic                                reset,
   // Input item channel.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [bhd_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,  // [0] pin_pressed, rest zero
   input  logic                                req_tuser,  // [0] func
   // Result item channel.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [bhd_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata,  // [0] long_press, [2:1] mode
   // Configuration write port.
   input  logic                                csr_we,
   input  logic [bhd_pkg::CSR_ADDR_WIDTH-1:0]  csr_addr,
   input  logic [bhd_pkg::CFG_WIDTH-1:0]       csr_wdata
);
   import bhd_pkg::*;

   bhd_cfg_type    cfg;
   bhd_result_type core_result;

   // The input register holds one item waiting for the step logic.
   logic           in_valid_ff;
   logic           in_valid_in;
   logic           in_func_ff;
   logic           in_pressed_ff;

   // The result register holds one finished result until it is taken.
   logic           out_valid_ff;
   logic           out_valid_in;
   bhd_result_type out_result_ff;

   logic           out_free;
   logic           step_en;
   logic           req_accept;

   // The result register can take a new result when it is empty or being
   // drained now; the step fires whenever an item waits and that is true.
   assign out_free   = !out_valid_ff || rsp_tready;
   assign step_en    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign req_accept = req_tvalid && req_tready;

   assign in_valid_in  = req_accept || (in_valid_ff && !step_en);
   assign out_valid_in = step_en || (out_valid_ff && !rsp_tready);

   bhd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bhd_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step_en     (step_en),
      .func        (in_func_ff),
      .pin_pressed (in_pressed_ff),
      .cfg         (cfg),
      .result      (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers load on their handshakes and need no reset.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_func_ff    <= req_tuser;
         in_pressed_ff <= req_tdata[0];
      end
      if (step_en) begin
         out_result_ff <= core_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_WIDTH - 3)'(0), out_result_ff.mode, out_result_ff.long_press};

`ifndef ASSERT_OFF
   // An item waiting in the input register is kept while the step is blocked.
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_free |=> in_valid_ff)
      else $error("waiting item dropped");

   // A long press always leaves the block idle.
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_result_ff.long_press |-> out_result_ff.mode == MODE_IDLE)
      else $error("long press result not idle");

   // A step only fires with room in the result register.
   assert property (@(posedge clock) disable iff (reset)
      step_en |=> out_valid_ff)
      else $error("result lost after step");
`endif

endmodule

// File: verif/button_hold_debouncer_checker.sv
`timescale 1ns / 100ps

module button_hold_debouncer_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [bhd_pkg::REQ_DATA_WIDTH-1:0] req_tdata,   // [0] pin_pressed, rest zero
   input  logic                               req_tuser,   // [0] func
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [bhd_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,   // [0] long_press, [2:1] mode
   input  logic                               csr_we,
   input  logic [bhd_pkg::CSR_ADDR_WIDTH-1:0] csr_addr,
   input  logic [bhd_pkg::CFG_WIDTH-1:0]      csr_wdata,
   output int                                 fail_count,
   output int                                 outstanding
);
   import bhd_pkg::*;

   // Shadow copy of the configuration registers.
   logic [CFG_WIDTH-1:0]   hold_cfg;
   logic [CFG_WIDTH-1:0]   press_cfg;
   logic [CFG_WIDTH-1:0]   chunk_cfg;

   // Shadow copy of the debouncer state.
   mode_type               mode_q;
   logic [COUNT_WIDTH-1:0] timer_q;
   logic                   timer_armed;
   logic [COUNT_WIDTH-1:0] hold_left;

   bhd_result_type         expected_status_q[$];
   int                     items_seen;
   int                     results_seen;

   assign outstanding = items_seen - results_seen;

   // Both counters are 16 bits wide like the registers, so loads never saturate.
   task automatic arm_hold_chunk();
      logic [COUNT_WIDTH-1:0] chunk;
      logic [COUNT_WIDTH-1:0] slice;
      chunk = (chunk_cfg == '0) ? COUNT_WIDTH'(1) : COUNT_WIDTH'(chunk_cfg);
      slice = (hold_left < chunk) ? hold_left : chunk;
      timer_q     = slice;
      timer_armed = 1'b1;
      hold_left   = hold_left - slice;
   endtask

   task automatic debounce_item(input func_type kind, input logic pressed,
                                output bhd_result_type status);
      logic expired;
      expired = 1'b0;
      status.long_press = 1'b0;
      if (kind == FUNC_TICK && timer_armed) begin
         if (timer_q <= COUNT_WIDTH'(1)) begin
            timer_q     = '0;
            timer_armed = 1'b0;
            expired     = 1'b1;
         end else begin
            timer_q = timer_q - 1'b1;
         end
      end
      case (mode_q)
         MODE_CONFIRM: begin
            if (expired) begin
               if (pressed) begin
                  arm_hold_chunk();
                  mode_q = MODE_HOLD;
               end else begin
                  mode_q = MODE_IDLE;
               end
            end
         end
         MODE_HOLD: begin
            if (expired) begin
               if (hold_left == '0) begin
                  status.long_press = pressed;
                  mode_q = MODE_IDLE;
               end else begin
                  arm_hold_chunk();
               end
            end else if (kind == FUNC_EDGE && pressed) begin
               // A new press restarts confirmation but keeps the remainder.
               timer_q     = COUNT_WIDTH'(press_cfg);
               timer_armed = 1'b1;
               mode_q      = MODE_CONFIRM;
            end
         end
         default: begin
            if (kind == FUNC_EDGE && pressed && hold_cfg != '0) begin
               hold_left   = COUNT_WIDTH'(hold_cfg);
               timer_q     = COUNT_WIDTH'(press_cfg);
               timer_armed = 1'b1;
               mode_q      = MODE_CONFIRM;
            end
         end
      endcase
      status.mode = mode_q;
   endtask

   always @(posedge clock) begin
      bhd_result_type status;
      bhd_result_type want;
      if (reset) begin
         hold_cfg     = HOLD_TIME_RESET;
         press_cfg    = PRESS_TIME_RESET;
         chunk_cfg    = CHUNK_TIME_RESET;
         mode_q       = MODE_IDLE;
         timer_q      = '0;
         timer_armed  = 1'b0;
         hold_left    = '0;
         expected_status_q.delete();
         items_seen   = 0;
         results_seen = 0;
         fail_count   = 0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_HOLD_TIME:  hold_cfg  = csr_wdata;
               CSR_PRESS_TIME: press_cfg = csr_wdata;
               CSR_CHUNK_TIME: chunk_cfg = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            debounce_item(func_type'(req_tuser), req_tdata[0], status);
            expected_status_q.push_back(status);
            items_seen = items_seen + 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_status_q.size() == 0) begin
               $display("%0t: result with none expected, got long_press %0b mode %0d",
                        $time, rsp_tdata[0], rsp_tdata[2:1]);
               fail_count = fail_count + 1;
            end else begin
               want = expected_status_q.pop_front();
               results_seen = results_seen + 1;
               if (rsp_tdata[0] !== want.long_press) begin
                  $display("%0t: long_press expected %0b, actual %0b",
                           $time, want.long_press, rsp_tdata[0]);
                  fail_count = fail_count + 1;
               end
               if (rsp_tdata[2:1] !== want.mode) begin
                  $display("%0t: mode expected %0d, actual %0d",
                           $time, want.mode, rsp_tdata[2:1]);
                  fail_count = fail_count + 1;
               end
            end
         end
      end
   end

endmodule

// File: verif/button_hold_debouncer_unit_test.sv
`timescale 1ns / 100ps

module button_hold_debouncer_unit_test;
   import bhd_pkg::*;

   // Every block input starts at a known value before the first clock edge.
   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata  = '0;   // [0] pin_pressed, rest zero
   logic                      req_tuser  = 1'b0; // [0] func
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b1;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;         // [0] long_press, [2:1] mode
   logic                      csr_we     = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_addr   = CSR_HOLD_TIME;
   logic [CFG_WIDTH-1:0]      csr_wdata  = '0;

   int fail_count;
   int outstanding;

   // Percentage that controls how often either side idles; zero means never.
   int idle_pct = 20;
   int stall_left = 0;
   int sent_items = 0;

   // The stimulus keeps its own copy of the settings to size press episodes.
   int hold_setting  = 0;
   int press_setting = 10;

   always #5 clock = ~clock;

   button_hold_debouncer_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   button_hold_debouncer_checker checker_inst (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // The result side stalls in random bursts. When idling is switched off any
   // burst in progress is dropped at once.
   always @(posedge clock) begin
      if (reset || idle_pct == 0) begin
         stall_left = 0;
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < idle_pct / 2) begin
         stall_left = $urandom_range(0, 11);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Presents one item and returns at the edge where it is accepted. A gap
   // with valid low may come first. Valid stays high on return so that
   // back-to-back items need no extra assignment.
   task automatic send_item(input func_type kind, input logic pressed);
      int gap;
      gap = 0;
      if ($urandom_range(0, 99) < idle_pct / 2) begin
         gap = $urandom_range(1, 12);
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= REQ_DATA_WIDTH'(pressed);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_items = sent_items + 1;
   endtask

   task automatic send_tick(input logic pressed);
      send_item(FUNC_TICK, pressed);
   endtask

   task automatic send_report(input logic pressed);
      send_item(FUNC_EDGE, pressed);
   endtask

   // Drops valid and waits until every predicted result has been checked.
   // The outstanding count is read on the falling edge so that it is never
   // sampled while the checker is still updating it.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      @(posedge clock);
   endtask

   // Writes all three registers on consecutive edges. Only called while the
   // block has nothing in flight.
   task automatic write_settings(input int hold_ticks, input int press_ticks,
                                 input int chunk_ticks);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_HOLD_TIME;
      csr_wdata <= CFG_WIDTH'(hold_ticks);
      @(posedge clock);
      csr_addr  <= CSR_PRESS_TIME;
      csr_wdata <= CFG_WIDTH'(press_ticks);
      @(posedge clock);
      csr_addr  <= CSR_CHUNK_TIME;
      csr_wdata <= CFG_WIDTH'(chunk_ticks);
      @(posedge clock);
      csr_we    <= 1'b0;
      hold_setting  = hold_ticks;
      press_setting = press_ticks;
   endtask

   // One button press: a pressed report, then roughly as many pressed ticks
   // as a long press needs (a few short of it or a few past it), with the
   // odd bounce, re-press or glitched tick mixed in, then a release.
   task automatic run_press_episode();
      int ticks;
      ticks = ((press_setting == 0) ? 1 : press_setting) + hold_setting
              + $urandom_range(0, 6) - 2;
      if (ticks < 1) begin
         ticks = 1;
      end
      send_report(1'b1);
      for (int i = 0; i < ticks; i++) begin
         case ($urandom_range(0, 39))
            0: send_report(1'b1);
            1: send_report(1'b0);
            2: send_tick(1'b0);
            default: ;
         endcase
         send_tick(1'b1);
      end
      send_report(1'b0);
      repeat ($urandom_range(0, 3)) send_tick(1'b0);
   endtask

   // A random phase picks mostly small settings so that long presses
   // complete often. Now and then the hold time is zero or fairly long, and
   // press and chunk times of zero come up regularly.
   task automatic run_random_phase(input int budget, input int idle_setting);
      int first_item;
      int hold_ticks;
      first_item = sent_items;
      idle_pct   = idle_setting;
      hold_ticks = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 30);
      if ($urandom_range(0, 4) == 0) begin
         hold_ticks = $urandom_range(31, 160);
      end
      write_settings(hold_ticks, $urandom_range(0, 8), $urandom_range(0, 12));
      while (sent_items - first_item < budget) begin
         if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 8)) begin
               send_item(func_type'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
         end else begin
            run_press_episode();
         end
      end
      drain_results();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // With the reset settings the hold time is zero, so a press is ignored.
      send_report(1'b1);
      send_tick(1'b1);
      drain_results();

      // Zero press time and zero chunk: confirmation ends on the first tick
      // and the hold is counted one tick at a time.
      write_settings(3, 0, 0);
      send_report(1'b1);   // enters confirmation
      send_report(1'b0);   // reports are ignored while confirming
      send_tick(1'b1);     // confirmation expires, first chunk armed
      send_report(1'b0);   // a release report is ignored while holding
      send_tick(1'b1);
      send_tick(1'b1);
      send_tick(1'b1);     // remainder is zero and the pin is held: long press
      send_report(1'b1);
      send_tick(1'b0);     // released at the end of confirmation: back to idle
      send_report(1'b1);
      send_tick(1'b1);
      send_report(1'b1);   // re-press restarts confirmation, remainder kept
      send_tick(1'b1);
      send_tick(1'b1);
      send_tick(1'b0);     // hold ends with the pin released: no long press
      drain_results();

      // Largest hold and chunk: the whole hold is taken in one chunk. A
      // re-press with zero press time and a released tick get out of it.
      write_settings(COUNT_MAX, 0, COUNT_MAX);
      send_report(1'b1);
      send_tick(1'b1);
      send_tick(1'b1);
      send_report(1'b0);
      send_report(1'b1);
      send_tick(1'b0);
      drain_results();

      // A longer press time, counted out in full without idling, followed by
      // the shortest possible hold.
      idle_pct = 0;
      write_settings(1, 40, 1);
      send_report(1'b1);
      repeat (39) send_tick(1'b1);
      send_tick(1'b1);     // confirmation expires with the pin held
      send_tick(1'b1);     // one-tick hold completes: long press
      drain_results();

      // Random phases, each with its own settings and amount of idling. The
      // last one runs without any idling on either side.
      run_random_phase(200, 30);
      run_random_phase(190, 0);
      run_random_phase(190, 60);
      run_random_phase(190, 15);
      run_random_phase(190, 45);
      run_random_phase(190, 0);

      // Let the pipeline settle.
      repeat (4) @(posedge clock);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Guard against a hang.
   initial begin
      #8000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/bhd_pkg.sv
hw/rtl/bhd_csr.sv
hw/rtl/bhd_core.sv
hw/rtl/button_hold_debouncer_unit.sv
verif/button_hold_debouncer_checker.sv
verif/button_hold_debouncer_unit_test.sv
